// File: rtl/core/bkconv_pkg.sv
// ----------------------------------------------------------------------------
// bkconv_pkg: shared types and constants of the binary kernel bank
// Reset values of the configuration registers, register indexes, the result
// beat layout and the 3x3 window type.
// ----------------------------------------------------------------------------
package bkconv_pkg;

  localparam int unsigned NUM_KERNELS    = 12;
  localparam int unsigned MASK_W         = 9;
  localparam int unsigned PIXEL_W        = 8;
  localparam int unsigned DIM_W          = 6;
  localparam int unsigned MASKS_W        = 54;
  localparam int unsigned SUM_W          = 12;
  localparam int unsigned KIDX_W         = 4;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam int unsigned DEF_MAX_WIDTH  = 32;
  localparam int unsigned DEF_MAX_HEIGHT = 32;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 6'd28;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 6'd28;
  localparam logic [MASKS_W-1:0] RST_MASKS_LOW    = 54'd12010692419022994;
  localparam logic [MASKS_W-1:0] RST_MASKS_HIGH   = 54'd2231729989178879;

  localparam logic [KIDX_W-1:0]  LAST_KERNEL = 4'd11;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MASKS_LOW    = 2'd2,
    CFG_MASKS_HIGH   = 2'd3
  } cfg_idx_e;

  // window pixel b sits at row b/3, column b%3 (row 0 oldest, column 0 oldest)
  typedef logic [MASK_W-1:0][PIXEL_W-1:0] win_t;

  typedef struct packed {
    logic [KIDX_W-1:0] kernel_index;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic [SUM_W-1:0]  window_sum;
    logic              last_of_run;
    logic              last_of_image;
  } result_t;

endpackage

// File: rtl/core/bkconv_pix_if.sv
// ----------------------------------------------------------------------------
// bkconv_pix_if: pixel stream channel
// Valid/ready channel carrying one grayscale pixel per beat.
// ----------------------------------------------------------------------------
interface bkconv_pix_if;
  logic                             valid;
  logic                             ready;
  logic [bkconv_pkg::PIXEL_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: rtl/core/bkconv_res_if.sv
// ----------------------------------------------------------------------------
// bkconv_res_if: kernel result channel
// Valid/ready channel carrying one kernel sum with its position per beat.
// ----------------------------------------------------------------------------
interface bkconv_res_if;
  logic                  valid;
  logic                  ready;
  bkconv_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/binary_kernel_bank_conv3x3.sv
// ----------------------------------------------------------------------------
// binary_kernel_bank_conv3x3: twelve binary 3x3 kernels over a pixel stream
// Pixels enter in raster order on pix_i. Once a full 3x3 window exists
// (row and column both at least 2) each pixel yields twelve result beats on
// res_o, kernel 0 first, each the sum of the window pixels selected by that
// kernel's nine-bit mask. last_of_run marks kernel 11, last_of_image marks
// kernel 11 of the image's final pixel.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, one register per write,
// image width, image height, masks of kernels 0-5, masks of kernels 6-11.
// Write only while the block is idle. Dimensions are clamped to 3..MAX.
// Flow: a pixel is taken while the window buffer is empty; its window moves
// from the window buffer to the job register, and each kernel's sum is
// registered in the result register. The result register is the bottleneck:
// one beat per cycle while res_o is ready. A one-deep window buffer lets the
// next pixel in while the twelve beats of the previous one drain.
// Reset clears counters, window and all valid flags; line stores are not
// cleared (their contents only matter once written). When res_o stalls,
// the result register holds and input stops once the window buffer is full.
// ----------------------------------------------------------------------------
module binary_kernel_bank_conv3x3 #(
  parameter int unsigned MAX_WIDTH  = bkconv_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bkconv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bkconv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bkconv_pkg::MASKS_W-1:0]       cfg_data_i,
  bkconv_pix_if.sink                           pix_i,
  bkconv_res_if.source                         res_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);       // column counter
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);      // row counter
  localparam int unsigned WUW = $clog2(MAX_WIDTH + 1);   // clamped width
  localparam int unsigned HUW = $clog2(MAX_HEIGHT + 1);  // clamped height
  localparam int unsigned PW  = bkconv_pkg::PIXEL_W;
  localparam int unsigned KW  = bkconv_pkg::KIDX_W;
  localparam int unsigned SW  = bkconv_pkg::SUM_W;
  localparam int unsigned PSW = bkconv_pkg::POS_W;
  localparam int unsigned MW  = bkconv_pkg::MASK_W;
  localparam int unsigned MSW = bkconv_pkg::MASKS_W;
  localparam int unsigned SELW = $clog2(2 * MSW);

  // one window waiting for or going through the kernel sequencer
  typedef struct packed {
    bkconv_pkg::win_t  win;
    logic [PSW-1:0]    row;
    logic [PSW-1:0]    col;
    logic              last_img;
  } job_t;

  // configuration registers
  logic [bkconv_pkg::DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic [MSW-1:0]               cfg_masks_lo_q, cfg_masks_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q    <= bkconv_pkg::RST_IMAGE_WIDTH;
      cfg_height_q   <= bkconv_pkg::RST_IMAGE_HEIGHT;
      cfg_masks_lo_q <= bkconv_pkg::RST_MASKS_LOW;
      cfg_masks_hi_q <= bkconv_pkg::RST_MASKS_HIGH;
    end else if (cfg_we_i) begin
      unique case (bkconv_pkg::cfg_idx_e'(cfg_idx_i))
        bkconv_pkg::CFG_IMAGE_WIDTH:  cfg_width_q    <= cfg_data_i[bkconv_pkg::DIM_W-1:0];
        bkconv_pkg::CFG_IMAGE_HEIGHT: cfg_height_q   <= cfg_data_i[bkconv_pkg::DIM_W-1:0];
        bkconv_pkg::CFG_MASKS_LOW:    cfg_masks_lo_q <= cfg_data_i;
        bkconv_pkg::CFG_MASKS_HIGH:   cfg_masks_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimensions in use, clamped to 3..MAX
  logic [WUW-1:0] width_use;
  logic [HUW-1:0] height_use;

  always_comb begin
    if (cfg_width_q < 6'd3) begin
      width_use = WUW'(3);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      width_use = WUW'(MAX_WIDTH);
    end else begin
      width_use = WUW'(cfg_width_q);
    end
    if (cfg_height_q < 6'd3) begin
      height_use = HUW'(3);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      height_use = HUW'(MAX_HEIGHT);
    end else begin
      height_use = HUW'(cfg_height_q);
    end
  end

  // position counters
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [WUW:0]   col_inc;
  logic [HUW:0]   row_inc;
  logic           end_col, end_row;
  logic           pix_accept, produce;

  assign col_inc = (WUW+1)'({1'b0, col_q}) + (WUW+1)'(1);
  assign row_inc = (HUW+1)'({1'b0, row_q}) + (HUW+1)'(1);
  assign end_col = col_inc >= (WUW+1)'(width_use);
  assign end_row = row_inc >= (HUW+1)'(height_use);
  assign produce = (col_q >= CW'(2)) && (row_q >= RW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_accept) begin
      if (end_col) begin
        col_d = '0;
        row_d = end_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // line stores: one entry per column holds {row r-2, row r-1}; the read for
  // the next pixel is issued as soon as its column is known
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] line_rd_q;
  logic [PW-1:0]   up_px, lo_px;

  assign up_px = line_rd_q[2*PW-1:PW];
  assign lo_px = line_rd_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      line_mem[col_q] <= {lo_px, pix_i.pixel};
    end
    line_rd_q <= line_mem[col_d];
  end

  // 3x3 window: shift left one column, new column on the right
  bkconv_pkg::win_t win_q, win_d;

  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = up_px;
    win_d[5] = lo_px;
    win_d[8] = pix_i.pixel;
  end

  // window buffer and kernel sequencer
  logic          pend_v_q, job_v_q, out_v_q;
  job_t          pend_q, job_q;
  logic [KW-1:0] kern_q;
  logic          fire, job_done, pend_take;
  bkconv_pkg::result_t out_q;

  assign pix_i.ready = !pend_v_q;
  assign pix_accept  = pix_i.valid && !pend_v_q;
  assign fire        = job_v_q && (!out_v_q || res_o.ready);
  assign job_done    = fire && (kern_q == bkconv_pkg::LAST_KERNEL);
  assign pend_take   = pend_v_q && (!job_v_q || job_done);

  // masked sum for the current kernel
  logic [2*MSW-1:0] masks_all;
  logic [MW-1:0]    kmask;
  logic [SW-1:0]    ksum;

  assign masks_all = {cfg_masks_hi_q, cfg_masks_lo_q};
  assign kmask     = masks_all[SELW'(kern_q) * SELW'(MW) +: MW];

  always_comb begin
    ksum = '0;
    for (int b = 0; b < MW; b++) begin
      if (kmask[b]) begin
        ksum = ksum + SW'(job_q.win[b]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      win_q    <= '0;
      pend_v_q <= 1'b0;
      job_v_q  <= 1'b0;
      kern_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (pix_accept) begin
        win_q <= win_d;
      end
      // pixel beats are taken only with an empty buffer, so a take and a
      // fill never meet in one cycle
      if (pix_accept && produce) begin
        pend_v_q <= 1'b1;
      end else if (pend_take) begin
        pend_v_q <= 1'b0;
      end
      if (pend_take) begin
        job_v_q <= 1'b1;
        kern_q  <= '0;
      end else if (job_done) begin
        job_v_q <= 1'b0;
      end else if (fire) begin
        kern_q <= kern_q + KW'(1);
      end
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pix_accept && produce) begin
      pend_q.win      <= win_d;
      pend_q.row      <= PSW'(row_q - RW'(2));
      pend_q.col      <= PSW'(col_q - CW'(2));
      pend_q.last_img <= end_col && end_row;
    end
    if (pend_take) begin
      job_q <= pend_q;
    end
    if (fire) begin
      out_q.kernel_index  <= kern_q;
      out_q.out_row       <= job_q.row;
      out_q.out_col       <= job_q.col;
      out_q.window_sum    <= ksum;
      out_q.last_of_run   <= kern_q == bkconv_pkg::LAST_KERNEL;
      out_q.last_of_image <= (kern_q == bkconv_pkg::LAST_KERNEL) && job_q.last_img;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

`ifndef SYNTHESIS
  // a run continues without a gap until its twelfth beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !res_o.data.last_of_run |=> res_o.valid)
    else $error("result run broken before its last kernel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.data.kernel_index <= bkconv_pkg::LAST_KERNEL)
    else $error("kernel index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.last_of_image |-> res_o.data.last_of_run)
    else $error("image end flagged off the last kernel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= CW'(MAX_WIDTH - 1)) && (row_q <= RW'(MAX_HEIGHT - 1)))
    else $error("position counter beyond line store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q && !job_v_q |=> job_v_q)
    else $error("waiting window not handed to sequencer");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of binary_kernel_bank_conv3x3
// Streams raster-order pixels through the kernel bank, keeps its own line
// stores and 3x3 window, and checks every result beat against the twelve
// masked sums of each full window. Frame sizes, masks and handshake pressure
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SETTLE_CYCLES = 4;     // covers a pixel that yields no beat
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no beat before giving up
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned MODE_PIXELS   = 15;    // pixels per handshake mode, at least

  // window model and queue of the sums still owed by the block
  class kernel_sum_board;
    logic [bkconv_pkg::DIM_W-1:0]   width_reg;
    logic [bkconv_pkg::DIM_W-1:0]   height_reg;
    logic [bkconv_pkg::MASKS_W-1:0] masks_lo;
    logic [bkconv_pkg::MASKS_W-1:0] masks_hi;
    logic [bkconv_pkg::PIXEL_W-1:0] upper_line [bkconv_pkg::DEF_MAX_WIDTH];
    logic [bkconv_pkg::PIXEL_W-1:0] lower_line [bkconv_pkg::DEF_MAX_WIDTH];
    bkconv_pkg::win_t               win;
    int unsigned                    col_cnt;
    int unsigned                    row_cnt;
    bkconv_pkg::result_t            pending_sums [$];
    int unsigned                    errors;

    function new();
      width_reg  = bkconv_pkg::RST_IMAGE_WIDTH;
      height_reg = bkconv_pkg::RST_IMAGE_HEIGHT;
      masks_lo   = bkconv_pkg::RST_MASKS_LOW;
      masks_hi   = bkconv_pkg::RST_MASKS_HIGH;
      win        = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
    endfunction

    function void write_reg(bkconv_pkg::cfg_idx_e idx, logic [bkconv_pkg::MASKS_W-1:0] data);
      case (idx)
        bkconv_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[bkconv_pkg::DIM_W-1:0];
        bkconv_pkg::CFG_IMAGE_HEIGHT: height_reg = data[bkconv_pkg::DIM_W-1:0];
        bkconv_pkg::CFG_MASKS_LOW:    masks_lo   = data;
        bkconv_pkg::CFG_MASKS_HIGH:   masks_hi   = data;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [bkconv_pkg::DIM_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function int unsigned width_in_use();
      return clamp_dim(width_reg, bkconv_pkg::DEF_MAX_WIDTH);
    endfunction

    function int unsigned height_in_use();
      return clamp_dim(height_reg, bkconv_pkg::DEF_MAX_HEIGHT);
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int unsigned outstanding();
      return pending_sums.size();
    endfunction

    // shift one pixel into the window and queue the sums it produces
    function void note_pixel(logic [bkconv_pkg::PIXEL_W-1:0] px);
      int unsigned                   w, h, c, sum;
      int                            r, k, b;
      logic [bkconv_pkg::MASK_W-1:0] m;
      bit                            end_col, end_row;
      bkconv_pkg::result_t           sum_beat;
      w = width_in_use();
      h = height_in_use();
      c = col_cnt % bkconv_pkg::DEF_MAX_WIDTH;
      end_col = (col_cnt + 1 >= w);
      end_row = (row_cnt + 1 >= h);
      for (r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = upper_line[c];
      win[5] = lower_line[c];
      win[8] = px;
      upper_line[c] = lower_line[c];
      lower_line[c] = px;
      if (col_cnt >= 2 && row_cnt >= 2) begin
        for (k = 0; k < bkconv_pkg::NUM_KERNELS; k++) begin
          m = (k < 6) ? masks_lo[bkconv_pkg::MASK_W*k +: bkconv_pkg::MASK_W]
                      : masks_hi[bkconv_pkg::MASK_W*(k-6) +: bkconv_pkg::MASK_W];
          sum = 0;
          for (b = 0; b < bkconv_pkg::MASK_W; b++)
            if (m[b]) sum += win[b];
          sum_beat.kernel_index  = bkconv_pkg::KIDX_W'(k);
          sum_beat.out_row       = bkconv_pkg::POS_W'(row_cnt - 2);
          sum_beat.out_col       = bkconv_pkg::POS_W'(col_cnt - 2);
          sum_beat.window_sum    = bkconv_pkg::SUM_W'(sum);
          sum_beat.last_of_run   = (k == bkconv_pkg::NUM_KERNELS - 1);
          sum_beat.last_of_image = (k == bkconv_pkg::NUM_KERNELS - 1) && end_col && end_row;
          pending_sums.insert(pending_sums.size(), sum_beat);
        end
      end
      if (end_col) begin
        col_cnt = 0;
        row_cnt = end_row ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    function void compare_field(string name, logic [bkconv_pkg::SUM_W-1:0] want,
                                logic [bkconv_pkg::SUM_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_beat(bkconv_pkg::result_t got);
      bkconv_pkg::result_t want;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got kernel %0d row %0d col %0d sum %0d",
                 $time, got.kernel_index, got.out_row, got.out_col, got.window_sum);
        return;
      end
      want = pending_sums.pop_front();
      compare_field("kernel_index", want.kernel_index, got.kernel_index);
      compare_field("out_row", want.out_row, got.out_row);
      compare_field("out_col", want.out_col, got.out_col);
      compare_field("window_sum", want.window_sum, got.window_sum);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
      compare_field("last_of_image", want.last_of_image, got.last_of_image);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  bkconv_pkg::cfg_idx_e           cfg_idx;
  logic [bkconv_pkg::MASKS_W-1:0] cfg_data;

  bkconv_pix_if pix ();
  bkconv_res_if res ();

  kernel_sum_board sums = new();

  // handshake pressure knobs, percent of cycles spent idle
  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 63;
  bit          hold_req      = 1'b0;
  int unsigned pixels_sent   = 0;

  binary_kernel_bank_conv3x3 dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix.valid && pix.ready) sums.note_pixel(pix.pixel);
      if (res.valid && res.ready) sums.check_beat(res.data);
    end
  end

  // result sink: random ready, or a long hold-off when asked for one
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without any beat on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // dimension word with junk above the six bits the block keeps
  function automatic logic [bkconv_pkg::MASKS_W-1:0] dim_word(int unsigned code);
    logic [bkconv_pkg::MASKS_W-1:0] word;
    word = bkconv_pkg::MASKS_W'({$urandom, $urandom});
    word[bkconv_pkg::DIM_W-1:0] = bkconv_pkg::DIM_W'(code);
    return word;
  endfunction

  // mostly random masks, with empty and full banks now and then
  function automatic logic [bkconv_pkg::MASKS_W-1:0] pick_masks();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return bkconv_pkg::MASKS_W'({$urandom, $urandom});
    endcase
  endfunction

  // all tasks start and end at a falling edge
  task automatic write_reg(bkconv_pkg::cfg_idx_e idx, logic [bkconv_pkg::MASKS_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sums.write_reg(idx, data);
  endtask

  // drop valid, let every owed beat arrive, then give the pipe time to empty
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sums.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // valid stays high into the next pixel unless the sender takes a gap
  task automatic send_pixel(logic [bkconv_pkg::PIXEL_W-1:0] px);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // one frame of random pixels, run until the counters wrap back to the origin;
  // a break shrinks or keeps the width and rewrites the height mid-frame, which is safe
  // since every column still in use has been written in the rows above
  task automatic feed_image(int break_at, bit squeeze);
    int n;
    n = 0;
    do begin
      if (n == break_at) begin
        wait_idle();
        write_reg(bkconv_pkg::CFG_IMAGE_WIDTH,
                  dim_word($urandom_range(3, sums.width_in_use())));
        write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word($urandom_range(3, 6)));
      end
      // once windows are full, starve the sink so the block backs up
      if (squeeze && n == 3 * sums.width_in_use()) hold_req = 1'b1;
      send_pixel(8'($urandom_range(255)));
      n++;
    end while (!sums.at_frame_start());
  endtask

  // small frame, sometimes with dimension codes below the floor
  task automatic random_image();
    int unsigned w_code, h_code, area;
    int          break_at;
    w_code = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
    h_code = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 5);
    wait_idle();
    write_reg(bkconv_pkg::CFG_IMAGE_WIDTH, dim_word(w_code));
    write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word(h_code));
    write_reg(bkconv_pkg::CFG_MASKS_LOW, pick_masks());
    write_reg(bkconv_pkg::CFG_MASKS_HIGH, pick_masks());
    area = sums.width_in_use() * sums.height_in_use();
    break_at = ($urandom_range(3) == 0) ? int'($urandom_range(1, area - 1)) : -1;
    feed_image(break_at, 1'b0);
  endtask

  initial begin
    int i;
    int mode;
    int unsigned mark;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = bkconv_pkg::CFG_IMAGE_WIDTH;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset masks on a 5x5 frame, cut after its first window: shrinking to
    // width 3 with the column counter already past the new last column makes
    // it wrap, and a height of 4 ends the frame one row later
    write_reg(bkconv_pkg::CFG_IMAGE_WIDTH, dim_word(5));
    write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word(5));
    for (i = 0; i < 13; i++)
      send_pixel((i < 4) ? ((i % 2 != 0) ? 8'hFF : 8'h00) : 8'($urandom_range(255)));
    wait_idle();
    write_reg(bkconv_pkg::CFG_IMAGE_WIDTH, dim_word(3));
    write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word(4));
    do send_pixel(8'($urandom_range(255))); while (!sums.at_frame_start());
    wait_idle();

    // saturated 3x3 frame: full masks give the largest sum, empty ones zero;
    // dimension codes under the floor clamp to 3
    write_reg(bkconv_pkg::CFG_MASKS_LOW, '1);
    write_reg(bkconv_pkg::CFG_MASKS_HIGH, '0);
    write_reg(bkconv_pkg::CFG_IMAGE_WIDTH, dim_word(2));
    write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word(0));
    repeat (9) send_pixel(8'hFF);

    // random frames: slow sender / stalling sink, then the reverse, then none
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 63 : 0;
      recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 20 : 0;
      mark = pixels_sent;
      while (pixels_sent - mark < MODE_PIXELS) random_image();
    end

    // short frame with the long sink hold-off in the middle of it
    wait_idle();
    write_reg(bkconv_pkg::CFG_IMAGE_WIDTH, dim_word(3));
    write_reg(bkconv_pkg::CFG_IMAGE_HEIGHT, dim_word(6));
    write_reg(bkconv_pkg::CFG_MASKS_HIGH, pick_masks());
    feed_image(-1, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sums.errors == 0 && sums.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
